@@ src/kvc_pkg.sv @@
// Package for the kinematic velocity clamp: mode codes, register indexes,
// pipeline carry type and small helper functions.
// No dependencies.
`default_nettype none
package kvc_pkg;

    // Operating modes held in the mode register
    typedef enum logic [1:0] {
        MODE_SEEK   = 2'd0,
        MODE_ARRIVE = 2'd1,
        MODE_FLEE   = 2'd2,
        MODE_OFF    = 2'd3
    } t_mode;

    // Configuration register indexes
    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_MAX_SPEED = 2'd1;
    localparam logic [1:0] REG_ATTEN     = 2'd2;

    localparam int SQRT_STEPS = 32;   // one root bit per stage
    localparam int DIV_STEPS  = 31;   // one quotient bit per stage

    // Control and component values that ride along the root/divide pipe
    typedef struct packed {
        logic             v;
        logic             clamp;
        logic             zero;
        logic [2:0]       neg;
        logic [2:0][31:0] c;
    } t_carry;

    // Magnitude of a signed 32-bit value (the most negative value maps to 2^31)
    function automatic logic [31:0] f_mag(input logic [31:0] v);
        f_mag = v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage
`default_nettype wire

@@ src/kinematic_velocity_clamp_top.sv @@
// Kinematic velocity clamp top level: seek / arrive / flee velocity in Q16.16.
// Uses kvc_pkg for mode codes, register indexes and the pipeline carry type.
`default_nettype none
// One item enters per clock and one result leaves per clock: o_busy is always
// low and start may be held high every cycle. The result of an item appears on
// the o_velocity_* ports with o_valid high once it has passed through the
// 5 front stages for difference, arrive scaling, squares and clamp test,
// 32 stages of the bit-per-stage square root, one divide entry register,
// 31 stages of the bit-per-stage divide and one output register. The receiver
// cannot stall the block. Write the configuration registers only while no item
// is in flight.
module kinematic_velocity_clamp_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [31:0] i_target_x,
    input  wire logic [31:0] i_target_y,
    input  wire logic [31:0] i_target_z,
    input  wire logic [31:0] i_position_x,
    input  wire logic [31:0] i_position_y,
    input  wire logic [31:0] i_position_z,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_wdata,
    output logic             o_valid,
    output logic [31:0]      o_velocity_x,
    output logic [31:0]      o_velocity_y,
    output logic [31:0]      o_velocity_z,
    output logic             o_was_clamped
);

    localparam int NS = kvc_pkg::SQRT_STEPS;
    localparam int ND = kvc_pkg::DIV_STEPS;

    // configuration registers
    kvc_pkg::t_mode r_mode;
    logic [30:0]    r_max_speed;
    logic [31:0]    r_atten;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= kvc_pkg::MODE_SEEK;
            r_max_speed <= 31'd65536;
            r_atten     <= 32'd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kvc_pkg::REG_MODE:      r_mode      <= kvc_pkg::t_mode'(i_cfg_wdata[1:0]);
                kvc_pkg::REG_MAX_SPEED: r_max_speed <= i_cfg_wdata[30:0];
                kvc_pkg::REG_ATTEN:     r_atten     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    logic        w_take;
    logic [31:0] w_tgt [3];
    logic [31:0] w_pos [3];
    assign w_take = i_start;
    assign w_tgt[0] = i_target_x;
    assign w_tgt[1] = i_target_y;
    assign w_tgt[2] = i_target_z;
    assign w_pos[0] = i_position_x;
    assign w_pos[1] = i_position_y;
    assign w_pos[2] = i_position_z;

    // stage 1: saturated difference
    logic r1_v;
    logic [2:0][31:0] r1_c;
    logic [2:0][31:0] n1_c;

    always_comb begin
        logic signed [32:0] d;
        for (int i = 0; i < 3; i++) begin
            if (r_mode == kvc_pkg::MODE_FLEE)
                d = $signed({w_pos[i][31], w_pos[i]}) - $signed({w_tgt[i][31], w_tgt[i]});
            else
                d = $signed({w_tgt[i][31], w_tgt[i]}) - $signed({w_pos[i][31], w_pos[i]});
            if (d[32] != d[31])
                n1_c[i] = d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else
                n1_c[i] = d[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else          r1_v <= w_take;
        r1_c <= n1_c;
    end

    // stage 2: arrive product |c| * attenuation_recip
    logic r2_v;
    logic [2:0][31:0] r2_c;
    logic [2:0][63:0] r2_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else          r2_v <= r1_v;
        r2_c <= r1_c;
        for (int i = 0; i < 3; i++)
            r2_prod[i] <= 64'(kvc_pkg::f_mag(r1_c[i])) * 64'(r_atten);
    end

    // stage 3: arrive shift, saturate, restore sign
    logic r3_v;
    logic [2:0][31:0] r3_c;
    logic [2:0][31:0] n3_c;

    always_comb begin
        logic [47:0] q;
        for (int i = 0; i < 3; i++) begin
            q = r2_prod[i][63:16];
            if (q > 48'h8000_0000)
                q = 48'h8000_0000;
            if (r_mode != kvc_pkg::MODE_ARRIVE)
                n3_c[i] = r2_c[i];
            else if (r2_c[i][31])
                n3_c[i] = ~q[31:0] + 32'd1;
            else if (q[31])
                n3_c[i] = 32'h7FFF_FFFF;
            else
                n3_c[i] = q[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else          r3_v <= r2_v;
        r3_c <= n3_c;
    end

    // stage 4: squares, divide numerators |c| * max_speed, max_speed squared
    logic r4_v;
    logic [2:0][31:0] r4_c;
    logic [2:0][63:0] r4_sq;
    logic [2:0][61:0] r4_num;
    logic [61:0]      r4_ms2;

    always_ff @(posedge i_clk) begin
        logic [31:0] m;
        if (!i_rst_n) r4_v <= 1'b0;
        else          r4_v <= r3_v;
        r4_c   <= r3_c;
        r4_ms2 <= 62'(r_max_speed) * 62'(r_max_speed);
        for (int i = 0; i < 3; i++) begin
            m = kvc_pkg::f_mag(r3_c[i]);
            r4_sq[i]  <= 64'(m) * 64'(m);
            r4_num[i] <= 62'(m) * 62'(r_max_speed);
        end
    end

    // stage 5: sum of squares and clamp decision, feeds the root pipe
    kvc_pkg::t_carry  r_sq_k   [NS+1];
    logic [63:0]      r_sq_n   [NS+1];
    logic [63:0]      r_sq_res [NS+1];
    logic [2:0][61:0] r_sq_num [NS+1];

    kvc_pkg::t_carry n5_k;
    logic [63:0]     n5_s;

    always_comb begin
        n5_s = r4_sq[0] + r4_sq[1] + r4_sq[2];
        n5_k.v    = r4_v;
        n5_k.zero = (r_mode == kvc_pkg::MODE_OFF);
        if (r_mode == kvc_pkg::MODE_FLEE)
            n5_k.clamp = (n5_s != 64'd0);
        else
            n5_k.clamp = (r_mode != kvc_pkg::MODE_OFF) && (n5_s > {2'b00, r4_ms2});
        for (int i = 0; i < 3; i++)
            n5_k.neg[i] = r4_c[i][31];
        n5_k.c = r4_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sq_k[0].v <= 1'b0;
        else          r_sq_k[0].v <= n5_k.v;
        r_sq_k[0].clamp <= n5_k.clamp;
        r_sq_k[0].zero  <= n5_k.zero;
        r_sq_k[0].neg   <= n5_k.neg;
        r_sq_k[0].c     <= n5_k.c;
        r_sq_n[0]       <= n5_s;
        r_sq_res[0]     <= 64'd0;
        r_sq_num[0]     <= r4_num;
    end

    // square root: one root bit per stage
    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] w_t;
        assign w_t = r_sq_res[k] + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sq_k[k+1].v <= 1'b0;
            else          r_sq_k[k+1].v <= r_sq_k[k].v;
            r_sq_k[k+1].clamp <= r_sq_k[k].clamp;
            r_sq_k[k+1].zero  <= r_sq_k[k].zero;
            r_sq_k[k+1].neg   <= r_sq_k[k].neg;
            r_sq_k[k+1].c     <= r_sq_k[k].c;
            r_sq_num[k+1]     <= r_sq_num[k];
            if (r_sq_n[k] >= w_t) begin
                r_sq_n[k+1]   <= r_sq_n[k] - w_t;
                r_sq_res[k+1] <= (r_sq_res[k] >> 1) + BIT;
            end else begin
                r_sq_n[k+1]   <= r_sq_n[k];
                r_sq_res[k+1] <= r_sq_res[k] >> 1;
            end
        end
    end

    // divide entry: length (at least 1), remainder seeded with the high numerator bits
    kvc_pkg::t_carry  r_dv_k    [ND+1];
    logic [31:0]      r_dv_len  [ND+1];
    logic [2:0][32:0] r_dv_rem  [ND+1];
    logic [2:0][30:0] r_dv_low  [ND+1];
    logic [2:0][30:0] r_dv_q    [ND+1];

    logic [31:0] w_len;
    assign w_len = (r_sq_res[NS][31:0] == 32'd0) ? 32'd1 : r_sq_res[NS][31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv_k[0].v <= 1'b0;
        else          r_dv_k[0].v <= r_sq_k[NS].v;
        r_dv_k[0].clamp <= r_sq_k[NS].clamp;
        r_dv_k[0].zero  <= r_sq_k[NS].zero;
        r_dv_k[0].neg   <= r_sq_k[NS].neg;
        r_dv_k[0].c     <= r_sq_k[NS].c;
        r_dv_len[0]     <= w_len;
        for (int i = 0; i < 3; i++) begin
            r_dv_rem[0][i] <= {2'b00, r_sq_num[NS][i][61:31]};
            r_dv_low[0][i] <= r_sq_num[NS][i][30:0];
            r_dv_q[0][i]   <= 31'd0;
        end
    end

    // restoring divide: one quotient bit per stage, three lanes share the length
    for (genvar j = 0; j < ND; j++) begin : g_div
        always_ff @(posedge i_clk) begin
            logic [32:0] t;
            if (!i_rst_n) r_dv_k[j+1].v <= 1'b0;
            else          r_dv_k[j+1].v <= r_dv_k[j].v;
            r_dv_k[j+1].clamp <= r_dv_k[j].clamp;
            r_dv_k[j+1].zero  <= r_dv_k[j].zero;
            r_dv_k[j+1].neg   <= r_dv_k[j].neg;
            r_dv_k[j+1].c     <= r_dv_k[j].c;
            r_dv_len[j+1]     <= r_dv_len[j];
            for (int i = 0; i < 3; i++) begin
                t = {r_dv_rem[j][i][31:0], r_dv_low[j][i][30]};
                r_dv_low[j+1][i] <= {r_dv_low[j][i][29:0], 1'b0};
                if (t >= {1'b0, r_dv_len[j]}) begin
                    r_dv_rem[j+1][i] <= t - {1'b0, r_dv_len[j]};
                    r_dv_q[j+1][i]   <= {r_dv_q[j][i][29:0], 1'b1};
                end else begin
                    r_dv_rem[j+1][i] <= t;
                    r_dv_q[j+1][i]   <= {r_dv_q[j][i][29:0], 1'b0};
                end
            end
        end
    end

    // output select: off mode gives zero, clamped gives signed quotient, else the component passes through
    logic [2:0][31:0] n_vel;
    logic [2:0][31:0] r_vel;
    logic             r_clamped;
    logic             r_out_v;

    always_comb begin
        kvc_pkg::t_carry k;
        k = r_dv_k[ND];
        for (int i = 0; i < 3; i++) begin
            if (k.zero)
                n_vel[i] = 32'd0;
            else if (k.clamp)
                n_vel[i] = k.neg[i] ? (~{1'b0, r_dv_q[ND][i]} + 32'd1) : {1'b0, r_dv_q[ND][i]};
            else
                n_vel[i] = k.c[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_v <= 1'b0;
        else          r_out_v <= r_dv_k[ND].v;
        r_vel     <= n_vel;
        r_clamped <= r_dv_k[ND].clamp && !r_dv_k[ND].zero;
    end

    assign o_valid       = r_out_v;
    assign o_velocity_x  = r_vel[0];
    assign o_velocity_y  = r_vel[1];
    assign o_velocity_z  = r_vel[2];
    assign o_was_clamped = r_clamped;

endmodule
`default_nettype wire
